[src/isb_pkg.sv]
// Package for the indexed sequence buffer: operation and status codes,
// field widths, and the control word broadcast to the element cells.
// No dependencies.
`default_nettype none

package isb_pkg;

   localparam int DEF_CAPACITY = 64;
   localparam int OP_W         = 4;
   localparam int POS_W        = 7;
   localparam int VAL_W        = 8;
   localparam int STAT_W       = 2;
   // Widest cell index over the supported capacity range (up to 4096 cells).
   localparam int IDX_MAX_W    = 12;

   typedef enum logic [OP_W-1:0] {
      OP_INS_FRONT = 4'd0,
      OP_INS_BACK  = 4'd1,
      OP_INS_AT    = 4'd2,
      OP_DEL_FRONT = 4'd3,
      OP_DEL_BACK  = 4'd4,
      OP_DEL_AT    = 4'd5,
      OP_READ      = 4'd6,
      OP_WRITE     = 4'd7,
      OP_CLEAR     = 4'd8
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_INSERT,
      CMD_DELETE,
      CMD_WRITE,
      CMD_READ
   } cmd_type;

   typedef struct packed {
      cmd_type                cmd;
      logic [IDX_MAX_W-1:0]   pos;
      logic [VAL_W-1:0]       value;
   } cell_ctl_type;

endpackage

`default_nettype wire

[src/indexed_sequence_buffer_top.sv]
// Indexed sequence buffer: an ordered byte sequence in a row of cells.
// Result path: the accept is registered in s1_valid_ff and then in rsp_valid_ff, which
// drives the result strobe; the status, count and read word are registered alongside it.
// Throughput: one item per cycle; every insert or delete that passes its checks
// shifts the row of cells by one place in the accepting cycle, and busy stays low.
// Reset: synchronous, clears the element count and the valid bits of the result
// pipeline; cell contents are undefined until written.
`default_nettype none

module indexed_sequence_buffer_top #(
   parameter  int CAPACITY = isb_pkg::DEF_CAPACITY,
   localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [isb_pkg::OP_W-1:0]      req_op,
   input  wire logic [isb_pkg::POS_W-1:0]     req_position,
   input  wire logic [isb_pkg::VAL_W-1:0]     req_value,
   output logic                               rsp_valid,
   output logic      [isb_pkg::VAL_W-1:0]     rsp_read_value,
   output logic      [isb_pkg::STAT_W-1:0]    rsp_status,
   output logic      [CNT_W-1:0]              rsp_count,
   output logic                               rsp_empty_res
);
   import isb_pkg::*;

   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
   localparam logic [CMP_W-1:0] CAP_W = CMP_W'(CAPACITY);

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              s1_valid_ff;
   status_type        s1_status_ff;
   logic [CNT_W-1:0]  s1_count_ff;
   logic              rsp_valid_ff;
   logic [VAL_W-1:0]  rsp_read_value_ff, rsp_read_value_in;
   status_type        rsp_status_ff;
   logic [CNT_W-1:0]  rsp_count_ff;

   logic              accept;
   cell_ctl_type      ctl;
   status_type        status;
   logic [CMP_W-1:0]  cnt_w;
   logic [CMP_W-1:0]  pos_w;
   logic [CMP_W-1:0]  tgt;

   logic [VAL_W-1:0]  cell_data [CAPACITY];
   logic [VAL_W-1:0]  cell_rd   [CAPACITY];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Command decode: range and fullness checks, the count update, and the command for the row.
   always_comb begin
      cnt_w     = CMP_W'(cnt_ff);
      pos_w     = CMP_W'(req_position);
      tgt       = pos_w;
      status    = ST_DONE;
      cnt_in    = cnt_ff;
      ctl.cmd   = CMD_NONE;
      ctl.value = req_value;
      case (op_type'(req_op))
         OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
            if (op_type'(req_op) == OP_INS_FRONT) begin
               tgt = '0;
            end else if (op_type'(req_op) == OP_INS_BACK) begin
               tgt = cnt_w;
            end
            if (tgt > cnt_w) begin
               status = ST_RANGE;
            end else if (cnt_w == CAP_W) begin
               status = ST_FULL;
            end else begin
               ctl.cmd = CMD_INSERT;
               cnt_in  = cnt_ff + CNT_W'(1);
            end
         end
         OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
            if (op_type'(req_op) == OP_DEL_FRONT) begin
               tgt = '0;
            end else if (op_type'(req_op) == OP_DEL_BACK) begin
               tgt = cnt_w - CMP_W'(1);
            end
            if (cnt_w == '0 || tgt >= cnt_w) begin
               status = ST_RANGE;
            end else begin
               ctl.cmd = CMD_DELETE;
               cnt_in  = cnt_ff - CNT_W'(1);
            end
         end
         OP_READ, OP_WRITE: begin
            if (tgt >= cnt_w) begin
               status = ST_RANGE;
            end else begin
               ctl.cmd = (op_type'(req_op) == OP_READ) ? CMD_READ : CMD_WRITE;
            end
         end
         OP_CLEAR: begin
            cnt_in = '0;
         end
         default: begin
            status = ST_RANGE;
         end
      endcase
      ctl.pos = IDX_MAX_W'(tgt);
      if (!accept) begin
         ctl.cmd = CMD_NONE;
         cnt_in  = cnt_ff;
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VAL_W-1:0] left_d, right_d;
      if (i == 0) begin : g_first
         assign left_d = '0;
      end else begin : g_mid_l
         assign left_d = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_d = '0;
      end else begin : g_mid_r
         assign right_d = cell_data[i+1];
      end
      isb_cell #(
         .CELL_INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .left_data  (left_d),
         .right_data (right_d),
         .data       (cell_data[i]),
         .rd_data    (cell_rd[i])
      );
   end

   // At most one cell holds a nonzero read word, so an OR across the row selects it.
   always_comb begin
      rsp_read_value_in = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rsp_read_value_in = rsp_read_value_in | cell_rd[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         s1_valid_ff  <= accept;
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_status_ff      <= status;
      s1_count_ff       <= cnt_in;
      rsp_read_value_ff <= rsp_read_value_in;
      rsp_status_ff     <= s1_status_ff;
      rsp_count_ff      <= s1_count_ff;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_empty_res  = (rsp_count_ff == '0);

endmodule

`default_nettype wire

[src/isb_cell.sv]
// One element cell of the indexed sequence buffer. It holds one byte and
// takes its neighbor's byte on shifts. Depends on isb_pkg.
`default_nettype none

module isb_cell #(
   parameter int CELL_INDEX = 0
) (
   input  wire logic                       clock,
   input  wire isb_pkg::cell_ctl_type      ctl,
   input  wire logic [isb_pkg::VAL_W-1:0]  left_data,
   input  wire logic [isb_pkg::VAL_W-1:0]  right_data,
   output logic      [isb_pkg::VAL_W-1:0]  data,
   output logic      [isb_pkg::VAL_W-1:0]  rd_data
);
   import isb_pkg::*;

   localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(CELL_INDEX);

   logic [VAL_W-1:0] data_ff, data_in;
   logic [VAL_W-1:0] rd_ff, rd_in;
   logic             hit;
   logic             after;

   always_comb begin
      hit     = (ctl.pos == MY_IDX);
      after   = (MY_IDX > ctl.pos);
      data_in = data_ff;
      case (ctl.cmd)
         CMD_INSERT: begin
            if (hit) begin
               data_in = ctl.value;
            end else if (after) begin
               data_in = left_data;
            end
         end
         CMD_DELETE: begin
            if (hit || after) begin
               data_in = right_data;
            end
         end
         CMD_WRITE: begin
            if (hit) begin
               data_in = ctl.value;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
      // Only the addressed cell contributes to the read; the rest give zero.
      rd_in = (ctl.cmd == CMD_READ && hit) ? data_ff : '0;
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      rd_ff   <= rd_in;
   end

   assign data    = data_ff;
   assign rd_data = rd_ff;

endmodule

`default_nettype wire
